[sv/slt_pkg.sv]
package slt_pkg;

  localparam int unsigned TableDepth = 256;
  localparam int unsigned IdxW  = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int unsigned CntW  = $clog2(TableDepth + 1);
  localparam int unsigned DistW = 18;
  localparam int unsigned DivW  = 43;
  localparam int unsigned DivCntW = 6;

  localparam logic [1:0] OpClear    = 2'd0;
  localparam logic [1:0] OpAppend   = 2'd1;
  localparam logic [1:0] OpLookup   = 2'd2;
  localparam logic [1:0] OpReserved = 2'd3;

  localparam logic [1:0] ModeNone    = 2'd0;
  localparam logic [1:0] ModeExact   = 2'd1;
  localparam logic [1:0] ModeInterp  = 2'd2;
  localparam logic [1:0] ModeNearest = 2'd3;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [2:0]  stage_kind;
    logic [7:0]  digit_count;
    logic [7:0]  limb_count;
    logic [7:0]  card_total;
    logic        key_cached;
    logic [15:0] in_bucket;
    logic [15:0] out_bucket;
    logic [31:0] entry_latency;
  } in_item_t;

  typedef struct packed {
    logic        hit_found;
    logic [1:0]  match_mode;
    logic [31:0] latency_out;
  } out_item_t;

  typedef enum logic [2:0] {
    SEL_NONE,
    SEL_EXACT,
    SEL_INTERP,
    SEL_LO,
    SEL_HI,
    SEL_BEST
  } res_sel_e;

  typedef struct packed {
    logic     scan_start;
    logic     scan_pass;
    logic     mul_start;
    logic     div_load;
    logic     res_load;
    res_sel_e res_sel;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
    logic div_done;
    logic out_busy;
    logic exact_hit;
    logic any_stage;
    logic have_lo;
    logic have_hi;
  } sts_t;

endpackage

[sv/slt_ctrl.sv]
module slt_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic [1:0]          in_opcode_i,
  output logic                in_ready_o,
  input  slt_pkg::sts_t       sts_i,
  output slt_pkg::cmd_t       cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN0,
    S_SCAN1,
    S_DIVL,
    S_DIV,
    S_FIN
  } state_e;

  state_e            state_q;
  slt_pkg::cmd_t     cmd_q;
  slt_pkg::res_sel_e sel_q;

  assign in_ready_o = (state_q == S_IDLE);
  assign cmd_o      = cmd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cmd_q   <= '0;
      sel_q   <= slt_pkg::SEL_NONE;
    end else begin
      cmd_q.scan_start <= 1'b0;
      cmd_q.mul_start  <= 1'b0;
      cmd_q.div_load   <= 1'b0;
      cmd_q.res_load   <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i && in_opcode_i == slt_pkg::OpLookup) begin
            cmd_q.scan_start <= 1'b1;
            cmd_q.scan_pass  <= 1'b0;
            state_q          <= S_SCAN0;
          end
        end
        S_SCAN0: begin
          if (sts_i.scan_done) begin
            if (sts_i.exact_hit) begin
              sel_q   <= slt_pkg::SEL_EXACT;
              state_q <= S_FIN;
            end else if (!sts_i.any_stage) begin
              sel_q   <= slt_pkg::SEL_NONE;
              state_q <= S_FIN;
            end else if (sts_i.have_lo && sts_i.have_hi) begin
              cmd_q.mul_start <= 1'b1;
              state_q         <= S_DIVL;
            end else if (sts_i.have_lo) begin
              sel_q   <= slt_pkg::SEL_LO;
              state_q <= S_FIN;
            end else if (sts_i.have_hi) begin
              sel_q   <= slt_pkg::SEL_HI;
              state_q <= S_FIN;
            end else begin
              cmd_q.scan_start <= 1'b1;
              cmd_q.scan_pass  <= 1'b1;
              state_q          <= S_SCAN1;
            end
          end
        end
        S_SCAN1: begin
          if (sts_i.scan_done) begin
            sel_q   <= slt_pkg::SEL_BEST;
            state_q <= S_FIN;
          end
        end
        S_DIVL: begin
          cmd_q.div_load <= 1'b1;
          state_q        <= S_DIV;
        end
        S_DIV: begin
          if (sts_i.div_done) begin
            sel_q   <= slt_pkg::SEL_INTERP;
            state_q <= S_FIN;
          end
        end
        S_FIN: begin
          if (!sts_i.out_busy) begin
            cmd_q.res_load <= 1'b1;
            cmd_q.res_sel  <= sel_q;
            state_q        <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

[sv/slt_dp.sv]
module slt_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_accept_i,
  input  slt_pkg::in_item_t   in_data_i,
  input  slt_pkg::cmd_t       cmd_i,
  output slt_pkg::sts_t       sts_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output slt_pkg::out_item_t  out_data_o
);

  localparam int unsigned Depth = slt_pkg::TableDepth;
  localparam int unsigned IdxW  = slt_pkg::IdxW;
  localparam int unsigned CntW  = slt_pkg::CntW;
  localparam int unsigned DistW = slt_pkg::DistW;
  localparam int unsigned DivW  = slt_pkg::DivW;
  localparam int unsigned DcW   = slt_pkg::DivCntW;

  // table storage: key {stage, hit, digits, limbs, cards}, buckets, latency
  logic [27:0] key_mem [Depth];
  logic [31:0] bkt_mem [Depth];
  logic [31:0] lat_mem [Depth];

  logic [CntW-1:0] count_q;
  slt_pkg::in_item_t q_q;

  logic [CntW-1:0] idx_q;
  logic            scanning_q, rd_vld_q, pass_q;
  logic [27:0]     rd_key_q;
  logic [31:0]     rd_bkt_q, rd_lat_q;

  logic            exact_q, any_q, have_lo_q, have_hi_q, have_best_q;
  logic [31:0]     exact_lat_q, lo_lat_q, hi_lat_q, best_lat_q;
  logic [7:0]      lo_card_q, hi_card_q;
  logic [DistW-1:0] best_q;

  logic [39:0]     prod0_q, prod1_q;
  logic [DivW-1:0] quo_q;
  logic [8:0]      rem_q, div_q;
  logic [DcW-1:0]  dcnt_q;

  slt_pkg::out_item_t out_q;
  logic               out_vld_q;

  logic do_append;
  assign do_append = in_accept_i && in_data_i.opcode == slt_pkg::OpAppend
                     && count_q < CntW'(Depth);

  always_ff @(posedge clk_i) begin
    if (do_append) begin
      key_mem[count_q[IdxW-1:0]] <= {in_data_i.stage_kind, in_data_i.key_cached,
                                     in_data_i.digit_count, in_data_i.limb_count,
                                     in_data_i.card_total};
      bkt_mem[count_q[IdxW-1:0]] <= {in_data_i.in_bucket, in_data_i.out_bucket};
      lat_mem[count_q[IdxW-1:0]] <= in_data_i.entry_latency;
    end
    if (scanning_q) begin
      rd_key_q <= key_mem[idx_q[IdxW-1:0]];
      rd_bkt_q <= bkt_mem[idx_q[IdxW-1:0]];
      rd_lat_q <= lat_mem[idx_q[IdxW-1:0]];
    end
  end

  // per entry compare
  logic [2:0]  e_stage;
  logic        e_hit;
  logic [7:0]  e_dig, e_limb, e_card;
  logic [15:0] e_ib, e_ob;
  logic        stage_eq, key_eq, bkt_ok, ib_both, ob_both;
  logic [7:0]  ad_dig, ad_limb, ad_card;
  logic [15:0] ad_ib, ad_ob;
  logic [DistW-1:0] wdist;

  always_comb begin
    {e_stage, e_hit, e_dig, e_limb, e_card} = rd_key_q;
    {e_ib, e_ob} = rd_bkt_q;
    stage_eq = e_stage == q_q.stage_kind;
    ib_both  = e_ib != 16'd0 && q_q.in_bucket != 16'd0;
    ob_both  = e_ob != 16'd0 && q_q.out_bucket != 16'd0;
    bkt_ok   = !(ib_both && e_ib != q_q.in_bucket) && !(ob_both && e_ob != q_q.out_bucket);
    key_eq   = e_hit == q_q.key_cached && e_dig == q_q.digit_count
               && e_limb == q_q.limb_count && bkt_ok;
    ad_dig  = (e_dig > q_q.digit_count) ? e_dig - q_q.digit_count : q_q.digit_count - e_dig;
    ad_limb = (e_limb > q_q.limb_count) ? e_limb - q_q.limb_count : q_q.limb_count - e_limb;
    ad_card = (e_card > q_q.card_total) ? e_card - q_q.card_total : q_q.card_total - e_card;
    ad_ib   = (e_ib > q_q.in_bucket) ? e_ib - q_q.in_bucket : q_q.in_bucket - e_ib;
    ad_ob   = (e_ob > q_q.out_bucket) ? e_ob - q_q.out_bucket : q_q.out_bucket - e_ob;
    wdist = DistW'(ad_dig) * DistW'(100) + DistW'(ad_limb) * DistW'(10)
          + (DistW'(ad_card) << 1)
          + (ib_both ? DistW'(ad_ib) : '0) + (ob_both ? DistW'(ad_ob) : '0)
          + ((e_hit != q_q.key_cached) ? DistW'(1000) : '0);
  end

  logic [7:0]       span;
  logic [40:0]      num;
  logic [9:0]       trial;
  assign span  = hi_card_q - lo_card_q;
  assign num   = 41'(prod0_q) + 41'(prod1_q);
  assign trial = {rem_q, quo_q[DivW-1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      scanning_q  <= 1'b0;
      rd_vld_q    <= 1'b0;
      idx_q       <= '0;
      pass_q      <= 1'b0;
      exact_q     <= 1'b0;
      any_q       <= 1'b0;
      have_lo_q   <= 1'b0;
      have_hi_q   <= 1'b0;
      have_best_q <= 1'b0;
      dcnt_q      <= '0;
      out_vld_q   <= 1'b0;
    end else begin
      if (in_accept_i) begin
        q_q <= in_data_i;
        if (in_data_i.opcode == slt_pkg::OpClear) count_q <= '0;
        else if (do_append) count_q <= count_q + CntW'(1);
      end

      // table sweep, one entry read per cycle
      rd_vld_q <= scanning_q;
      if (cmd_i.scan_start) begin
        idx_q      <= '0;
        scanning_q <= count_q != '0;
        pass_q     <= cmd_i.scan_pass;
        if (!cmd_i.scan_pass) begin
          exact_q   <= 1'b0;
          any_q     <= 1'b0;
          have_lo_q <= 1'b0;
          have_hi_q <= 1'b0;
        end else begin
          have_best_q <= 1'b0;
        end
      end else if (scanning_q) begin
        idx_q      <= idx_q + CntW'(1);
        scanning_q <= (idx_q + CntW'(1)) != count_q;
      end

      if (rd_vld_q && stage_eq) begin
        if (!pass_q) begin
          if (!exact_q) begin
            any_q <= 1'b1;
            if (key_eq) begin
              if (e_card == q_q.card_total) begin
                exact_q     <= 1'b1;
                exact_lat_q <= rd_lat_q;
              end else if (e_card < q_q.card_total) begin
                if (!have_lo_q || e_card >= lo_card_q) begin
                  lo_card_q <= e_card;
                  lo_lat_q  <= rd_lat_q;
                end
                have_lo_q <= 1'b1;
              end else begin
                if (!have_hi_q || e_card < hi_card_q) begin
                  hi_card_q <= e_card;
                  hi_lat_q  <= rd_lat_q;
                end
                have_hi_q <= 1'b1;
              end
            end
          end
        end else if (!have_best_q || wdist < best_q) begin
          have_best_q <= 1'b1;
          best_q      <= wdist;
          best_lat_q  <= rd_lat_q;
        end
      end

      // interpolation products, then restoring division one bit a cycle
      if (cmd_i.mul_start) begin
        prod0_q <= lo_lat_q * (hi_card_q - q_q.card_total);
        prod1_q <= hi_lat_q * (q_q.card_total - lo_card_q);
      end
      if (cmd_i.div_load) begin
        quo_q  <= DivW'({num, 1'b0}) + DivW'(span);
        div_q  <= {span, 1'b0};
        rem_q  <= '0;
        dcnt_q <= DcW'(DivW);
      end else if (dcnt_q != '0) begin
        dcnt_q <= dcnt_q - DcW'(1);
        if (trial >= {1'b0, div_q}) begin
          rem_q <= 9'(trial - {1'b0, div_q});
          quo_q <= {quo_q[DivW-2:0], 1'b1};
        end else begin
          rem_q <= trial[8:0];
          quo_q <= {quo_q[DivW-2:0], 1'b0};
        end
      end

      if (out_vld_q && out_ready_i) out_vld_q <= 1'b0;
      if (cmd_i.res_load) out_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      case (cmd_i.res_sel)
        slt_pkg::SEL_EXACT:  out_q <= {1'b1, slt_pkg::ModeExact, exact_lat_q};
        slt_pkg::SEL_INTERP: out_q <= {1'b1, slt_pkg::ModeInterp, quo_q[31:0]};
        slt_pkg::SEL_LO:     out_q <= {1'b1, slt_pkg::ModeNearest, lo_lat_q};
        slt_pkg::SEL_HI:     out_q <= {1'b1, slt_pkg::ModeNearest, hi_lat_q};
        slt_pkg::SEL_BEST:   out_q <= {1'b1, slt_pkg::ModeNearest, best_lat_q};
        default:             out_q <= {1'b0, slt_pkg::ModeNone, 32'd0};
      endcase
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  assign sts_o.scan_done = !cmd_i.scan_start && !scanning_q && !rd_vld_q;
  assign sts_o.div_done  = !cmd_i.div_load && dcnt_q == '0;
  assign sts_o.out_busy  = out_vld_q;
  assign sts_o.exact_hit = exact_q;
  assign sts_o.any_stage = any_q;
  assign sts_o.have_lo   = have_lo_q;
  assign sts_o.have_hi   = have_hi_q;

endmodule

[sv/stage_latency_table_lookup_core.sv]
// stage latency table lookup
// input channel (in_valid_i / in_ready_o / in_data_i) takes one transaction
// per item: clear table, append entry, or lookup; only lookups produce a
// transaction on the output channel (out_valid_o / out_ready_i / out_data_o)
// clear and append complete in the accept cycle; appends to a full table
// (256 entries) are dropped
// a lookup sweeps the table once (one read per cycle from the single table
// port) looking for an exact match and the nearest lower and upper card
// counts; interpolation adds a registered multiply step and a bit-serial
// divider; with no candidate a second sweep finds the least weighted
// distance
// one lookup is in flight at a time; in_ready_o is high whenever the
// controller is idle, also while a result sits in the output register
// if the receiver stalls, the next lookup finishes its work and then waits
// until the held result is taken
// reset empties the table (entry contents are not cleared) and drops any
// pending result
module stage_latency_table_lookup_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  slt_pkg::in_item_t   in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output slt_pkg::out_item_t  out_data_o
);

  slt_pkg::cmd_t cmd;
  slt_pkg::sts_t sts;
  logic          in_accept;

  // accepted input transaction
  assign in_accept = in_valid_i && in_ready_o;

  // sequencer: sweeps, interpolation, result hand-off
  slt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_opcode_i (in_data_i.opcode),
    .in_ready_o  (in_ready_o),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // table memory, compare logic, divider and output register
  slt_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_accept_i (in_accept),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

[bench/stage_latency_table_lookup_core_test.sv]
`timescale 1ns / 1ps

module stage_latency_table_lookup_core_test;

  localparam int unsigned DEPTH = slt_pkg::TableDepth;
  localparam int unsigned IDLE_LIMIT = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  slt_pkg::in_item_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  slt_pkg::out_item_t out_data_o;

  stage_latency_table_lookup_core uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always #6 clk_i = ~clk_i;

  // local copy of the latency table
  slt_pkg::in_item_t  tbl_row [DEPTH];
  int unsigned tbl_rows;
  slt_pkg::out_item_t pending_latency_q [$];

  int unsigned mismatch_count;
  int unsigned idle_cycles;
  int unsigned burst_left;
  bit stall_enable;

  function automatic logic [15:0] absd(input logic [15:0] a, input logic [15:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic bit buckets_agree(input slt_pkg::in_item_t e, input slt_pkg::in_item_t q);
    if (e.in_bucket != 0 && q.in_bucket != 0 && e.in_bucket != q.in_bucket) return 0;
    if (e.out_bucket != 0 && q.out_bucket != 0 && e.out_bucket != q.out_bucket) return 0;
    return 1;
  endfunction

  // works out the lookup answer for the current table contents
  function automatic slt_pkg::out_item_t lookup_latency(input slt_pkg::in_item_t q);
    slt_pkg::out_item_t r;
    bit any_stage, have_lo, have_hi;
    int unsigned lo, hi;
    logic [1:0] mode;
    logic [31:0] res;
    logic [63:0] x0, x1, span, num, wgt, best;
    slt_pkg::in_item_t e;
    any_stage = 0; have_lo = 0; have_hi = 0; lo = 0; hi = 0;
    mode = slt_pkg::ModeNone; res = '0;
    for (int unsigned i = 0; i < tbl_rows && mode == slt_pkg::ModeNone; i++) begin
      e = tbl_row[i];
      if (e.stage_kind != q.stage_kind) continue;
      any_stage = 1;
      if (e.key_cached != q.key_cached || e.digit_count != q.digit_count ||
          e.limb_count != q.limb_count || !buckets_agree(e, q)) continue;
      if (e.card_total == q.card_total) begin
        mode = slt_pkg::ModeExact;
        res = e.entry_latency;
      end else if (e.card_total < q.card_total) begin
        if (!have_lo || e.card_total >= tbl_row[lo].card_total) lo = i;
        have_lo = 1;
      end else begin
        if (!have_hi || e.card_total < tbl_row[hi].card_total) hi = i;
        have_hi = 1;
      end
    end
    if (mode == slt_pkg::ModeNone && any_stage) begin
      if (have_lo && have_hi) begin
        x0 = 64'(tbl_row[lo].card_total);
        x1 = 64'(tbl_row[hi].card_total);
        span = x1 - x0;
        num = 64'(tbl_row[lo].entry_latency) * (x1 - 64'(q.card_total)) +
              64'(tbl_row[hi].entry_latency) * (64'(q.card_total) - x0);
        res = 32'((64'd2 * num + span) / (64'd2 * span));
        mode = slt_pkg::ModeInterp;
      end else if (have_lo) begin
        res = tbl_row[lo].entry_latency; mode = slt_pkg::ModeNearest;
      end else if (have_hi) begin
        res = tbl_row[hi].entry_latency; mode = slt_pkg::ModeNearest;
      end else begin
        best = '1;
        for (int unsigned i = 0; i < tbl_rows; i++) begin
          e = tbl_row[i];
          if (e.stage_kind != q.stage_kind) continue;
          wgt = 64'(absd(16'(e.digit_count), 16'(q.digit_count))) * 64'd100 +
                64'(absd(16'(e.limb_count), 16'(q.limb_count))) * 64'd10 +
                64'(absd(16'(e.card_total), 16'(q.card_total))) * 64'd2;
          if (e.in_bucket != 0 && q.in_bucket != 0)
            wgt += 64'(absd(e.in_bucket, q.in_bucket));
          if (e.out_bucket != 0 && q.out_bucket != 0)
            wgt += 64'(absd(e.out_bucket, q.out_bucket));
          if (e.key_cached != q.key_cached) wgt += 64'd1000;
          if (wgt < best) begin
            best = wgt;
            res = e.entry_latency;
          end
        end
        mode = slt_pkg::ModeNearest;
      end
    end
    r.hit_found = (mode != slt_pkg::ModeNone);
    r.match_mode = mode;
    r.latency_out = (mode != slt_pkg::ModeNone) ? res : '0;
    return r;
  endfunction

  // update the local table and queue an expected result for lookups
  function automatic void track_item(input slt_pkg::in_item_t it);
    case (it.opcode)
      slt_pkg::OpClear: begin
        tbl_rows = 0;
      end
      slt_pkg::OpAppend: begin
        if (tbl_rows < DEPTH) begin
          tbl_row[tbl_rows] = it;
          tbl_rows++;
        end
      end
      slt_pkg::OpLookup: begin
        pending_latency_q = {pending_latency_q, lookup_latency(it)};
      end
      default: begin
      end
    endcase
  endfunction

  // sends one transaction, with bursty gaps ahead of it
  task automatic send_item(input slt_pkg::in_item_t it);
    int unsigned gap;
    gap = 0;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      burst_left = $urandom_range(1, 12);
    end
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_data_i <= it;
    do @(posedge clk_i); while (!in_ready_o);
    track_item(it);
    @(negedge clk_i);
  endtask

  function automatic slt_pkg::in_item_t make_item(input logic [1:0] op, input logic [2:0] stg,
                                         input logic [7:0] dg, input logic [7:0] lb,
                                         input logic [7:0] cd, input logic hit,
                                         input logic [15:0] ib, input logic [15:0] ob,
                                         input logic [31:0] lat);
    slt_pkg::in_item_t it;
    it.opcode = op; it.stage_kind = stg; it.digit_count = dg; it.limb_count = lb;
    it.card_total = cd; it.key_cached = hit; it.in_bucket = ib; it.out_bucket = ob;
    it.entry_latency = lat;
    return it;
  endfunction

  function automatic slt_pkg::in_item_t rand_item(input logic [1:0] op);
    slt_pkg::in_item_t it;
    it = slt_pkg::in_item_t'(94'({$urandom, $urandom, $urandom}));
    it.opcode = op;
    return it;
  endfunction

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_latency_q.size() != 0) @(negedge clk_i);
    repeat (700) @(negedge clk_i);
  endtask

  // receiver stall pattern and result checker
  always @(negedge clk_i) begin
    if (!stall_enable) out_ready_i <= 1'b1;
    else out_ready_i <= ($urandom_range(0, 3) != 0);
  end

  always @(posedge clk_i) begin
    slt_pkg::out_item_t exp_r;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_latency_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected result %p", out_data_o);
      end else begin
        exp_r = pending_latency_q.pop_front();
        if (out_data_o.hit_found !== exp_r.hit_found ||
            out_data_o.match_mode !== exp_r.match_mode ||
            out_data_o.latency_out !== exp_r.latency_out) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("lookup mismatch: expected %p got %p", exp_r, out_data_o);
        end
      end
    end
  end

  // watchdog: cycles with no transaction on either channel
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // lookups against an empty table, a missing stage, and table clear
  task automatic test_empty_table();
    send_item(make_item(slt_pkg::OpLookup, 3'd0, 8'd0, 8'd0, 8'd0, 1'b0, 16'd0, 16'd0,
                        32'd0));
    send_item(make_item(slt_pkg::OpAppend, 3'd7, 8'd255, 8'd255, 8'd255, 1'b1, 16'hffff,
                        16'hffff, 32'hffff_ffff));
    send_item(make_item(slt_pkg::OpLookup, 3'd2, 8'd1, 8'd1, 8'd1, 1'b0, 16'd0, 16'd0,
                        32'd0));
    send_item(make_item(slt_pkg::OpLookup, 3'd7, 8'd255, 8'd255, 8'd255, 1'b1, 16'hffff,
                        16'hffff, 32'd0));
    send_item(make_item(slt_pkg::OpReserved, 3'd7, 8'd255, 8'd255, 8'd255, 1'b1, 16'hffff,
                        16'hffff, 32'hffff_ffff));
    send_item(make_item(slt_pkg::OpClear, 3'd0, 8'd0, 8'd0, 8'd0, 1'b0, 16'd0, 16'd0,
                        32'd0));
    send_item(make_item(slt_pkg::OpLookup, 3'd7, 8'd255, 8'd255, 8'd255, 1'b1, 16'd0,
                        16'd0, 32'd0));
  endtask

  // exact, interpolated, one-sided nearest, zero cards, and weighted distance
  task automatic test_match_modes();
    send_item(make_item(slt_pkg::OpAppend, 3'd3, 8'd4, 8'd8, 8'd0, 1'b1, 16'd0, 16'd0,
                        32'd100));
    send_item(make_item(slt_pkg::OpAppend, 3'd3, 8'd4, 8'd8, 8'd10, 1'b1, 16'd5, 16'd0,
                        32'd203));
    send_item(make_item(slt_pkg::OpAppend, 3'd3, 8'd4, 8'd8, 8'd255, 1'b1, 16'd0, 16'd9,
                        32'hffff_ffff));
    send_item(make_item(slt_pkg::OpLookup, 3'd3, 8'd4, 8'd8, 8'd10, 1'b1, 16'd0, 16'd0,
                        32'd0));
    send_item(make_item(slt_pkg::OpLookup, 3'd3, 8'd4, 8'd8, 8'd3, 1'b1, 16'd5, 16'd9,
                        32'd0));
    send_item(make_item(slt_pkg::OpLookup, 3'd3, 8'd4, 8'd8, 8'd100, 1'b1, 16'd0, 16'd0,
                        32'd0));
    send_item(make_item(slt_pkg::OpLookup, 3'd3, 8'd4, 8'd8, 8'd10, 1'b1, 16'd6, 16'd0,
                        32'd0));
    send_item(make_item(slt_pkg::OpLookup, 3'd3, 8'd4, 8'd8, 8'd255, 1'b0, 16'd0, 16'd0,
                        32'd0));
    send_item(make_item(slt_pkg::OpLookup, 3'd3, 8'd0, 8'd255, 8'd7, 1'b1, 16'hffff, 16'h1,
                        32'd0));
    send_item(make_item(slt_pkg::OpAppend, 3'd6, 8'd4, 8'd8, 8'd20, 1'b0, 16'd0, 16'd0,
                        32'd50));
    send_item(make_item(slt_pkg::OpLookup, 3'd6, 8'd4, 8'd8, 8'd30, 1'b0, 16'd0, 16'd0,
                        32'd0));
    send_item(make_item(slt_pkg::OpLookup, 3'd6, 8'd4, 8'd8, 8'd5, 1'b0, 16'd0, 16'd0,
                        32'd0));
  endtask

  // fill the table past its depth; the extra appends are dropped
  task automatic test_full_table();
    slt_pkg::in_item_t it;
    send_item(make_item(slt_pkg::OpClear, 3'd0, 8'd0, 8'd0, 8'd0, 1'b0, 16'd0, 16'd0,
                        32'd0));
    for (int i = 0; i < DEPTH + 4; i++) begin
      it = rand_item(slt_pkg::OpAppend);
      it.stage_kind = 3'($urandom_range(0, 1));
      it.digit_count = 8'($urandom_range(0, 3));
      it.limb_count = 8'($urandom_range(0, 3));
      send_item(it);
    end
    for (int i = 0; i < 6; i++) begin
      it = rand_item(slt_pkg::OpLookup);
      it.stage_kind = 3'($urandom_range(0, 2));
      it.digit_count = 8'($urandom_range(0, 3));
      it.limb_count = 8'($urandom_range(0, 3));
      send_item(it);
    end
  endtask

  // random traffic: small tables of clustered entries so lookups hit every path
  task automatic test_random_traffic();
    slt_pkg::in_item_t it;
    int unsigned pick;
    for (int n = 0; n < 465; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 3) it = rand_item(slt_pkg::OpClear);
      else if (pick < 5) it = rand_item(slt_pkg::OpReserved);
      else begin
        it = rand_item((pick < 50) ? slt_pkg::OpAppend : slt_pkg::OpLookup);
        if ($urandom_range(0, 9) != 0) begin
          it.stage_kind = 3'($urandom_range(0, 2));
          it.digit_count = 8'($urandom_range(1, 2));
          it.limb_count = 8'($urandom_range(1, 2));
          if ($urandom_range(0, 1)) it.in_bucket = '0;
          if ($urandom_range(0, 1)) it.out_bucket = '0;
          if ($urandom_range(0, 2) == 0) begin
            it.in_bucket = 16'($urandom_range(1, 2));
            it.out_bucket = 16'($urandom_range(0, 2));
          end
        end
      end
      send_item(it);
      if (n == 200) wait_drained();
    end
  endtask

  initial begin
    tbl_rows = 0;
    mismatch_count = 0;
    idle_cycles = 0;
    burst_left = 0;
    stall_enable = 1'b0;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_empty_table();
    stall_enable = 1'b1;
    test_match_modes();
    test_full_table();
    test_random_traffic();
    wait_drained();
    if (mismatch_count == 0 && pending_latency_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
